/* hdl/rlif_pkg.sv */
// Package for the routing link initialization machine: line state and event codes,
// the event/state transition table, and the item, config and timer structs.
// No dependencies; rlif_core and routing_link_init_fsm import it.
package rlif_pkg;

   // Config port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_AREA     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTER_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_NODE     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECALL_TICKS = 2'd3;

   // Request codes on req_type; 11..15 are unused
   localparam logic [3:0] REQ_INIT_MSG    = 4'd0;
   localparam logic [3:0] REQ_VERIFY_MSG  = 4'd1;
   localparam logic [3:0] REQ_INVALID_MSG = 4'd2;
   localparam logic [3:0] REQ_LINE_RUN    = 4'd3;
   localparam logic [3:0] REQ_START_ERR   = 4'd4;
   localparam logic [3:0] REQ_OP_ON       = 4'd5;
   localparam logic [3:0] REQ_OP_OFF      = 4'd6;
   localparam logic [3:0] REQ_ROUTE_DONE  = 4'd7;
   localparam logic [3:0] REQ_DOWN_DONE   = 4'd8;
   localparam logic [3:0] REQ_UP_DONE     = 4'd9;
   localparam logic [3:0] REQ_TICK        = 4'd10;

   // Router levels
   localparam logic [1:0] LEVEL_ONE = 2'd1;
   localparam logic [1:0] LEVEL_TWO = 2'd2;

   // Line state as a binary code (output and table index)
   localparam logic [2:0] C_RUN      = 3'd0;
   localparam logic [2:0] C_REJECTED = 3'd1;
   localparam logic [2:0] C_START    = 3'd2;
   localparam logic [2:0] C_INIT     = 3'd3;
   localparam logic [2:0] C_VERIFY   = 3'd4;
   localparam logic [2:0] C_COMPLETE = 3'd5;
   localparam logic [2:0] C_OFF      = 3'd6;
   localparam logic [2:0] C_HALT     = 3'd7;

   // Line state register, one-hot
   typedef enum logic [7:0] {
      ST_RUN      = 8'b0000_0001,
      ST_REJECTED = 8'b0000_0010,
      ST_START    = 8'b0000_0100,
      ST_INIT     = 8'b0000_1000,
      ST_VERIFY   = 8'b0001_0000,
      ST_COMPLETE = 8'b0010_0000,
      ST_OFF      = 8'b0100_0000,
      ST_HALT     = 8'b1000_0000
   } lstate_type;

   // Table events; EV_NONE selects identity rows
   typedef enum logic [3:0] {
      EV_NRI_VERIFY   = 4'd0,
      EV_NRI_NOVERIFY = 4'd1,
      EV_NRV          = 4'd2,
      EV_RECALL       = 4'd3,
      EV_LINE_RUN     = 4'd4,
      EV_START_ERR    = 4'd5,
      EV_OP_ON        = 4'd6,
      EV_OP_OFF       = 4'd7,
      EV_INVALID_MSG  = 4'd8,
      EV_ROUTE_DONE   = 4'd9,
      EV_DOWN_DONE    = 4'd10,
      EV_UP_DONE      = 4'd11,
      EV_NONE         = 4'd12
   } ev_type;

   // Actions
   localparam logic [2:0] A_NONE   = 3'd0;
   localparam logic [2:0] A_REINIT = 3'd1;
   localparam logic [2:0] A_STOP   = 3'd2;
   localparam logic [2:0] A_INIT   = 3'd3;
   localparam logic [2:0] A_VERIFY = 3'd4;

   // Table entry: {action, next state code}
   typedef logic [5:0] tent_type;

   // Rows by event, columns by state code: RUN REJ START INIT VERIFY COMPLETE OFF HALT
   localparam tent_type TRANS_TBL [16][8] = '{
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_VERIFY, C_VERIFY}, {A_REINIT, C_START}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_VERIFY}, {A_REINIT, C_START}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_REINIT, C_START}, {A_NONE, C_COMPLETE}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_REINIT, C_START},
         {A_REINIT, C_START}, {A_REINIT, C_START}, {A_NONE, C_COMPLETE},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_INIT, C_INIT},
         {A_REINIT, C_START}, {A_REINIT, C_START}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_REINIT, C_START},
         {A_REINIT, C_START}, {A_REINIT, C_START}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_REJECTED}, {A_REINIT, C_START} },
      '{ {A_STOP, C_OFF}, {A_NONE, C_OFF}, {A_STOP, C_HALT},
         {A_STOP, C_HALT}, {A_STOP, C_HALT}, {A_STOP, C_HALT},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_REINIT, C_START}, {A_REINIT, C_START}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_REJECTED}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_REINIT, C_START},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_REINIT, C_START}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_HALT}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_RUN},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} },
      '{ {A_NONE, C_RUN}, {A_NONE, C_REJECTED}, {A_NONE, C_START},
         {A_NONE, C_INIT}, {A_NONE, C_VERIFY}, {A_NONE, C_COMPLETE},
         {A_NONE, C_OFF}, {A_NONE, C_HALT} }
   };

   typedef struct packed {
      logic [3:0] req_type;
      logic [5:0] src_area;
      logic [9:0] src_node;
      logic       peer_is_level1;
      logic       verify_requested;
      logic       version_ok;
   } req_item_type;

   typedef struct packed {
      logic [2:0] line_state;
      logic       send_init;
      logic       send_verify;
      logic       start_line;
      logic       halt_line;
      logic       circuit_up;
      logic       circuit_down;
      logic       adjacency_init;
      logic       adjacency_check;
      logic       init_rejected;
   } rsp_item_type;

   typedef struct packed {
      logic [5:0]  own_area;
      logic [1:0]  router_level;
      logic [9:0]  max_node;
      logic [15:0] recall_ticks;
   } cfg_type;

   typedef struct packed {
      logic        active;
      logic [15:0] left;
   } timer_type;

   function automatic logic [2:0] state_code(input lstate_type st);
      logic [2:0] c;
      unique case (st)
         ST_RUN:      c = C_RUN;
         ST_REJECTED: c = C_REJECTED;
         ST_START:    c = C_START;
         ST_INIT:     c = C_INIT;
         ST_VERIFY:   c = C_VERIFY;
         ST_COMPLETE: c = C_COMPLETE;
         ST_OFF:      c = C_OFF;
         ST_HALT:     c = C_HALT;
         default:     c = C_OFF;
      endcase
      return c;
   endfunction

   function automatic lstate_type state_onehot(input logic [2:0] c);
      lstate_type st;
      unique case (c)
         C_RUN:      st = ST_RUN;
         C_REJECTED: st = ST_REJECTED;
         C_START:    st = ST_START;
         C_INIT:     st = ST_INIT;
         C_VERIFY:   st = ST_VERIFY;
         C_COMPLETE: st = ST_COMPLETE;
         C_OFF:      st = ST_OFF;
         C_HALT:     st = ST_HALT;
         default:    st = ST_OFF;
      endcase
      return st;
   endfunction

endpackage

/* hdl/rlif_req_if.sv */
// Request channel: valid/ready plus one event item.
// Depends on nothing.
interface rlif_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] req_type;
   logic [5:0] src_area;
   logic [9:0] src_node;
   logic       peer_is_level1;
   logic       verify_requested;
   logic       version_ok;

   modport source (output valid, req_type, src_area, src_node, peer_is_level1,
                   verify_requested, version_ok, input ready);
   modport sink (input valid, req_type, src_area, src_node, peer_is_level1,
                 verify_requested, version_ok, output ready);
endinterface

/* hdl/rlif_rsp_if.sv */
// Result channel: valid/ready plus line state and action flags.
// Depends on nothing.
interface rlif_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] line_state;
   logic       send_init;
   logic       send_verify;
   logic       start_line;
   logic       halt_line;
   logic       circuit_up;
   logic       circuit_down;
   logic       adjacency_init;
   logic       adjacency_check;
   logic       init_rejected;

   modport source (output valid, line_state, send_init, send_verify, start_line,
                   halt_line, circuit_up, circuit_down, adjacency_init,
                   adjacency_check, init_rejected, input ready);
   modport sink (input valid, line_state, send_init, send_verify, start_line,
                 halt_line, circuit_up, circuit_down, adjacency_init,
                 adjacency_check, init_rejected, output ready);
endinterface

/* hdl/rlif_core.sv */
// Next-state logic for one event: message checks, recall timer, and up to
// four table steps (primary event, its sub-event, forced down, its sub-event).
// Depends on rlif_pkg.
module rlif_core (
   input  rlif_pkg::req_item_type item_i,
   input  rlif_pkg::cfg_type      cfg_i,
   input  rlif_pkg::lstate_type   state_i,
   input  rlif_pkg::timer_type    timer_i,
   output rlif_pkg::lstate_type   state_o,
   output rlif_pkg::timer_type    timer_o,
   output rlif_pkg::rsp_item_type rsp_o
);
   import rlif_pkg::*;

   logic       msg_ok;
   logic       area_ok;
   ev_type     ev_a;
   ev_type     ev_b;
   ev_type     ev_cur;
   ev_type     follow;
   tent_type   ent;
   logic [2:0] nxt;
   logic [2:0] code_q [5];
   timer_type  tmr;
   rsp_item_type res;

   // Init message validity
   always_comb begin
      area_ok = 1'b1;
      if (item_i.src_node > cfg_i.max_node)
         area_ok = 1'b0;
      else if (cfg_i.router_level == LEVEL_ONE && item_i.src_area != cfg_i.own_area)
         area_ok = 1'b0;
      else if (cfg_i.router_level == LEVEL_TWO && item_i.peer_is_level1 &&
               item_i.src_area != cfg_i.own_area)
         area_ok = 1'b0;
      msg_ok = area_ok & item_i.version_ok;
   end

   always_comb begin
      res       = '0;
      tmr       = timer_i;
      ev_a      = EV_NONE;
      ev_b      = EV_NONE;
      code_q[0] = state_code(state_i);

      case (item_i.req_type)
         REQ_INIT_MSG: begin
            if (msg_ok) begin
               ev_a               = item_i.verify_requested ? EV_NRI_VERIFY : EV_NRI_NOVERIFY;
               res.adjacency_init = 1'b1;
            end else begin
               res.init_rejected = 1'b1;
               res.circuit_down  = 1'b1;
               ev_a              = EV_INVALID_MSG;
               ev_b              = EV_DOWN_DONE;
            end
         end
         REQ_VERIFY_MSG: begin
            ev_a                = EV_NRV;
            res.adjacency_check = 1'b1;
         end
         REQ_INVALID_MSG: begin
            res.circuit_down = 1'b1;
            ev_a             = EV_INVALID_MSG;
            ev_b             = EV_DOWN_DONE;
         end
         REQ_LINE_RUN:   ev_a = EV_LINE_RUN;
         REQ_START_ERR:  ev_a = EV_START_ERR;
         REQ_OP_ON:      ev_a = EV_OP_ON;
         REQ_OP_OFF:     ev_a = EV_OP_OFF;
         REQ_ROUTE_DONE: ev_a = EV_ROUTE_DONE;
         REQ_DOWN_DONE:  ev_a = EV_DOWN_DONE;
         REQ_UP_DONE:    ev_a = EV_UP_DONE;
         REQ_TICK: begin
            if (timer_i.active) begin
               if (timer_i.left <= 16'd1) begin
                  tmr.left   = '0;
                  tmr.active = 1'b0;
                  if (code_q[0] != C_RUN)
                     ev_a = EV_RECALL;
               end else begin
                  tmr.left = timer_i.left - 16'd1;
               end
            end
         end
         default: ;
      endcase

      // Any event's sub-event never raises another, so two steps per event suffice
      follow = EV_NONE;
      for (int k = 0; k < 4; k++) begin
         if (k == 0)
            ev_cur = ev_a;
         else if (k == 2)
            ev_cur = ev_b;
         else
            ev_cur = follow;
         ent    = TRANS_TBL[ev_cur][code_q[k]];
         nxt    = ent[2:0];
         follow = EV_NONE;
         unique case (ent[5:3])
            A_REINIT: begin
               if (!tmr.active) begin
                  res.start_line = 1'b1;
                  tmr.active     = 1'b1;
                  tmr.left       = cfg_i.recall_ticks;
               end
            end
            A_STOP:   res.halt_line   = 1'b1;
            A_INIT:   res.send_init   = 1'b1;
            A_VERIFY: res.send_verify = 1'b1;
            default: ;
         endcase
         if (nxt != code_q[k]) begin
            if (nxt == C_COMPLETE) begin
               res.circuit_up = 1'b1;
               follow         = EV_UP_DONE;
            end else if (nxt == C_REJECTED || nxt == C_OFF) begin
               res.circuit_down = 1'b1;
               follow           = EV_DOWN_DONE;
            end
         end
         code_q[k+1] = nxt;
      end

      res.line_state = code_q[4];
   end

   assign state_o = state_onehot(code_q[4]);
   assign timer_o = tmr;
   assign rsp_o   = res;

endmodule

/* hdl/routing_link_init_fsm.sv */
// Routing link initialization machine, one point-to-point circuit.
// A req transfer is captured in the input register, then its result in the result register,
// which drives rsp valid; the result register holds its result while rsp is not ready.
// Throughput: one event per cycle while rsp_if.ready is high; the whole event, sub-events
// included, resolves in one combinational pass through rlif_core between the two registers.
// Reset (synchronous, active high): line off, recall timer idle, config at defaults,
// both stages empty.
module routing_link_init_fsm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rlif_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rlif_pkg::CSR_DATA_W-1:0]       csr_wdata,
   rlif_req_if.sink                              req_if,
   rlif_rsp_if.source                            rsp_if
);
   import rlif_pkg::*;

   // Config registers
   cfg_type      cfg_ff;

   // Line state and recall timer; updated only when an item leaves the input stage
   lstate_type   link_state_ff;
   lstate_type   link_state_in;
   timer_type    timer_ff;
   timer_type    timer_in;

   // Input stage
   logic         req_vld_ff;
   req_item_type req_ff;

   // Result stage
   logic         rsp_vld_ff;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;

   // Stage advance: result register empty or being drained this cycle
   logic         adv;
   logic         fire;

   assign adv  = !rsp_vld_ff || rsp_if.ready;
   assign fire = req_vld_ff && adv;

   // Input stage takes a new transfer whenever its content moves on (or it is empty);
   // a waiting result blocks the input only once the input stage is also full.
   assign req_if.ready = !req_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_area     <= 6'd1;
         cfg_ff.router_level <= LEVEL_ONE;
         cfg_ff.max_node     <= 10'd1023;
         cfg_ff.recall_ticks <= 16'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_AREA:     cfg_ff.own_area     <= csr_wdata[5:0];
            CSR_ROUTER_LEVEL: cfg_ff.router_level <= csr_wdata[1:0];
            CSR_MAX_NODE:     cfg_ff.max_node     <= csr_wdata[9:0];
            CSR_RECALL_TICKS: cfg_ff.recall_ticks <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         req_ff.req_type         <= req_if.req_type;
         req_ff.src_area         <= req_if.src_area;
         req_ff.src_node         <= req_if.src_node;
         req_ff.peer_is_level1   <= req_if.peer_is_level1;
         req_ff.verify_requested <= req_if.verify_requested;
         req_ff.version_ok       <= req_if.version_ok;
      end
   end

   // Event decode, table walk and timer update
   rlif_core u_core (
      .item_i  (req_ff),
      .cfg_i   (cfg_ff),
      .state_i (link_state_ff),
      .timer_i (timer_ff),
      .state_o (link_state_in),
      .timer_o (timer_in),
      .rsp_o   (rsp_in)
   );

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff <= ST_OFF;
         timer_ff      <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (fire) begin
            link_state_ff <= link_state_in;
            timer_ff      <= timer_in;
         end
         if (adv)
            rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire)
         rsp_ff <= rsp_in;
   end

   assign rsp_if.valid           = rsp_vld_ff;
   assign rsp_if.line_state      = rsp_ff.line_state;
   assign rsp_if.send_init       = rsp_ff.send_init;
   assign rsp_if.send_verify     = rsp_ff.send_verify;
   assign rsp_if.start_line      = rsp_ff.start_line;
   assign rsp_if.halt_line       = rsp_ff.halt_line;
   assign rsp_if.circuit_up      = rsp_ff.circuit_up;
   assign rsp_if.circuit_down    = rsp_ff.circuit_down;
   assign rsp_if.adjacency_init  = rsp_ff.adjacency_init;
   assign rsp_if.adjacency_check = rsp_ff.adjacency_check;
   assign rsp_if.init_rejected   = rsp_ff.init_rejected;

endmodule
